### rtl/core/lrrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrb_pkg
// Shared types and constants for the line record ring buffer.
// ----------------------------------------------------------------------------
package lrrb_pkg;

    localparam int BUF_LEN_DEF   = 1024;
    localparam int MAX_LINES_DEF = 64;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_OLDEST = 3'd1,
        KIND_NEWEST = 3'd2,
        KIND_AFTER  = 3'd3,
        KIND_BYTE   = 3'd4
    } kind_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_in;
        logic        end_of_line;
        logic [15:0] query_id;
        logic [9:0]  byte_pos;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] line_no;
        logic [9:0]  first_pos;
        logic [9:0]  term_pos;
        logic [7:0]  data_out;
    } rsp_t;

endpackage

### rtl/core/line_record_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_record_ring_buffer
// Ring byte store of text lines with a circular line descriptor table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one transfer is one item. Appends
//   write one byte unless truncated; end_of_line commits the line (terminator, id, table slot).
//   rsp channel (rsp_valid/rsp_stall/rsp): exactly one transfer per item.
// Steps from acceptance to result transfer:
//   Non-final append, unknown kind, busy or empty-table read: answered from S_READ.
//   Read of oldest, newest or a stored byte: one memory read, answered from S_RESP.
//   Commit: terminator write, eviction of at most MAX_LINES lines, then the table slot.
//   Read-after-id walks the table from the oldest line, slot by slot
//   (advance, then wait for the read data).
//   The descriptor table read port is registered, hence the waits for read data.
// One item is in flight at a time; req_stall is high from acceptance until
// its result is transferred, so the next item can be accepted in the cycle after
// that. A stalled result holds in the output register.
// Reset empties the table and clears all counters; memory contents stay
// undefined, and a byte read of a position not yet written returns undefined data.
// ----------------------------------------------------------------------------
module line_record_ring_buffer #(
    parameter int BUF_LEN   = lrrb_pkg::BUF_LEN_DEF,
    parameter int MAX_LINES = lrrb_pkg::MAX_LINES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lrrb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lrrb_pkg::rsp_t rsp
);
    import lrrb_pkg::*;

    localparam int AW = $clog2(BUF_LEN);
    localparam int SW = $clog2(MAX_LINES);
    localparam int DW = 2 * AW + 16;
    localparam int LW = AW + 1;
    localparam logic [AW:0] LEN_MAX = LW'(BUF_LEN - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_LINES - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVICT = 6'b000100,
        S_WALK  = 6'b001000,
        S_RESP  = 6'b010000,
        S_TERM  = 6'b100000
    } state_t;

    typedef struct packed {
        logic [15:0]   id;
        logic [AW-1:0] first;
        logic [AW-1:0] term;
    } desc_t;

    // memories
    logic [7:0] byte_mem [BUF_LEN];
    logic [DW-1:0] tab_mem [MAX_LINES];

    state_t        state_reg;
    req_t          req_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;
    logic          empty_reg;
    logic [SW-1:0] oldest_reg, newest_reg;
    logic          open_reg;
    logic [AW-1:0] wpos_reg, ostart_reg;
    logic [AW:0]   olen_reg;
    logic [15:0]   next_no_reg;
    logic [SW:0]   count_reg;
    logic [SW-1:0] ptr_reg;
    desc_t         new_reg;
    logic [1:0]    cst_reg;

    logic [7:0]    bdata_reg;
    desc_t         tdata;
    logic [DW-1:0] tdata_raw_reg;
    logic [SW-1:0] tab_raddr;
    logic [SW-1:0] tab_raddr_q;
    logic          tab_we;
    logic [SW-1:0] tab_waddr;
    logic          byte_we;
    logic [AW-1:0] byte_waddr;
    logic [7:0]    byte_wdata;

    assign tdata = desc_t'(tdata_raw_reg);
    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    wire accept = req_valid && !req_stall;
    wire [SW-1:0] slot_new = (newest_reg == SLOT_LAST) ? '0 : newest_reg + 1'b1;

    function automatic logic [AW-1:0] rdist(logic [AW-1:0] t, logic [AW-1:0] f);
        rdist = (t >= f) ? t - f : t + AW'(BUF_LEN) - f;
    endfunction

    function automatic logic covers(logic [AW-1:0] p, desc_t d);
        covers = rdist(p, d.first) <= rdist(d.term, d.first);
    endfunction

    function automatic logic [SW-1:0] inc(logic [SW-1:0] s);
        inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [AW-1:0] winc(logic [AW-1:0] p);
        winc = (p == AW'(BUF_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

    // lines held from oldest to newest, inclusive
    function automatic logic [SW:0] span_count(logic [SW-1:0] n, logic [SW-1:0] o);
        if (n >= o)
            span_count = (SW+1)'(n - o) + 1'b1;
        else
            span_count = (SW+1)'(MAX_LINES) - (SW+1)'(o - n) + 1'b1;
    endfunction

    function automatic rsp_t mk_rsp(logic [1:0] st, logic [15:0] no,
                                    logic [AW-1:0] f, logic [AW-1:0] t,
                                    logic [7:0] d);
        mk_rsp.status    = st;
        mk_rsp.line_no   = no;
        mk_rsp.first_pos = 10'(f);
        mk_rsp.term_pos  = 10'(t);
        mk_rsp.data_out  = d;
    endfunction

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        bdata_reg <= byte_mem[req_reg.byte_pos[AW-1:0]];
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= DW'(new_reg);
        end
        tdata_raw_reg <= tab_mem[tab_raddr];
    end

    // address of the data now in tdata_raw_reg
    always_ff @(posedge clk)
    begin
        tab_raddr_q <= tab_raddr;
    end

    logic ov;
    assign ov = covers(tdata.first, new_reg) || covers(new_reg.first, tdata);

    // memory ports; the table is written once per commit, into the new slot
    always_comb
    begin
        tab_raddr  = ptr_reg;
        tab_we     = (state_reg == S_RESP) && (req_reg.kind == KIND_APPEND);
        tab_waddr  = newest_reg;
        byte_we    = 1'b0;
        byte_waddr = wpos_reg;
        byte_wdata = req_reg.data_in;
        if (state_reg == S_TERM)
        begin
            byte_we = 1'b1;
            byte_wdata = 8'd0;
        end
        if (state_reg == S_READ && req_reg.kind == KIND_APPEND && olen_reg < LEN_MAX)
        begin
            byte_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            empty_reg     <= 1'b1;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            open_reg      <= 1'b0;
            wpos_reg      <= '0;
            ostart_reg    <= '0;
            olen_reg      <= '0;
            next_no_reg   <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cst_reg       <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // result register only drains here; accept needs it empty
                    if (rsp_valid_reg && !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        req_reg   <= req;
                        state_reg <= S_READ;
                        ptr_reg   <= (req.kind == KIND_NEWEST) ? newest_reg : oldest_reg;
                        if (req.kind == KIND_APPEND && !open_reg)
                        begin
                            open_reg   <= 1'b1;
                            ostart_reg <= wpos_reg;
                            olen_reg   <= '0;
                        end
                    end
                end
                S_READ:
                begin
                    // table/byte read for ptr_reg issued this cycle
                    if (req_reg.kind == KIND_APPEND)
                    begin
                        if (olen_reg < LEN_MAX)
                        begin
                            wpos_reg <= winc(wpos_reg);
                            olen_reg <= olen_reg + 1'b1;
                            cst_reg  <= ST_OK;
                        end
                        else
                        begin
                            olen_reg <= LW'(BUF_LEN);
                            cst_reg  <= ST_TRUNC;
                        end
                        if (!req_reg.end_of_line)
                        begin
                            rsp_reg <= mk_rsp((olen_reg >= LEN_MAX) ? ST_TRUNC : ST_OK,
                                              next_no_reg, ostart_reg, '0, '0);
                            rsp_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_TERM;
                        end
                    end
                    else if (req_reg.kind > KIND_BYTE)
                    begin
                        rsp_reg       <= mk_rsp(ST_NONE, '0, '0, '0, '0);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (open_reg)
                    begin
                        rsp_reg       <= mk_rsp(ST_BUSY, '0, '0, '0, '0);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (req_reg.kind == KIND_BYTE)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (empty_reg)
                    begin
                        rsp_reg       <= mk_rsp(ST_NONE, '0, '0, '0, '0);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= '0;
                        state_reg <= (req_reg.kind == KIND_AFTER) ? S_WALK : S_RESP;
                    end
                end
                S_TERM:
                begin
                    // terminator written at wpos_reg this cycle
                    new_reg.id    <= next_no_reg;
                    new_reg.first <= ostart_reg;
                    new_reg.term  <= wpos_reg;
                    wpos_reg      <= winc(wpos_reg);
                    next_no_reg   <= next_no_reg + 1'b1;
                    open_reg      <= 1'b0;
                    olen_reg      <= '0;
                    ptr_reg       <= oldest_reg;
                    count_reg     <= empty_reg ? '0 : span_count(newest_reg, oldest_reg);
                    state_reg     <= S_EVICT;
                end
                S_EVICT:
                begin
                    // tdata valid for ptr_reg == oldest_reg once read settles
                    if (empty_reg || count_reg == '0)
                    begin
                        if (empty_reg)
                        begin
                            newest_reg <= '0;
                            oldest_reg <= '0;
                        end
                        else
                        begin
                            newest_reg <= slot_new;
                            oldest_reg <= slot_new;
                        end
                        empty_reg <= 1'b0;
                        state_reg <= S_RESP;
                    end
                    else if (ptr_reg != oldest_reg)
                    begin
                        ptr_reg <= oldest_reg;
                    end
                    else if (tab_raddr_q == oldest_reg && (ov || oldest_reg == slot_new))
                    begin
                        oldest_reg <= inc(oldest_reg);
                        ptr_reg    <= inc(oldest_reg);
                        count_reg  <= count_reg - 1'b1;
                    end
                    else if (tab_raddr_q == oldest_reg)
                    begin
                        newest_reg <= slot_new;
                        state_reg  <= S_RESP;
                    end
                end
                S_WALK:
                begin
                    if (tab_raddr_q != ptr_reg)
                    begin
                        // wait for read data of ptr_reg
                    end
                    else if (ptr_reg == newest_reg || count_reg == (SW+1)'(MAX_LINES))
                    begin
                        rsp_reg       <= mk_rsp(ST_NONE, '0, '0, '0, '0);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (tdata.id == req_reg.query_id)
                    begin
                        ptr_reg   <= inc(ptr_reg);
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        ptr_reg   <= inc(ptr_reg);
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (tab_raddr_q == ptr_reg || req_reg.kind == KIND_BYTE
                        || req_reg.kind == KIND_APPEND)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (req_reg.kind == KIND_BYTE)
                        begin
                            rsp_reg <= mk_rsp(ST_OK, '0, '0, '0, bdata_reg);
                        end
                        else if (req_reg.kind == KIND_APPEND)
                        begin
                            rsp_reg <= mk_rsp(cst_reg, new_reg.id, new_reg.first,
                                              new_reg.term, '0);
                        end
                        else
                        begin
                            rsp_reg <= mk_rsp(ST_OK, tdata.id, tdata.first,
                                              tdata.term, '0);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall) else $error("result pending while accepting");
    a_no_read_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !open_reg) else $error("walk with open line");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        olen_reg <= LW'(BUF_LEN)) else $error("length overflow");

endmodule

### bench/line_record_ring_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_record_ring_buffer_test
// Random and directed test of the line ring buffer: a queue-fed driver sends
// appends and reads in bursts, a monitor checks each response transfer
// against an in-bench model of the byte store and the line descriptor table.
// ----------------------------------------------------------------------------
module line_record_ring_buffer_test;
    import lrrb_pkg::*;

    localparam int NBUF   = BUF_LEN_DEF;
    localparam int NLINES = MAX_LINES_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    line_record_ring_buffer uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // Model state, mirrors the block's store and descriptor table
    logic [7:0]  store_mem [NBUF];
    logic [9:0]  tbl_first [NLINES];
    logic [9:0]  tbl_term [NLINES];
    logic [15:0] tbl_id [NLINES];
    bit          tbl_empty;
    int          oldest_idx;
    int          newest_idx;
    bit          open_flag;
    int          wr_pos;
    int          open_first;
    int          open_len;
    logic [15:0] next_id;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   error_count;
    int   cycle_count;
    bit   hold_sender;
    bit   req_taken;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int ring_gap(int to, int from);
        return (to + NBUF - from) % NBUF;
    endfunction

    function automatic bit pos_in_span(int p, int s, int e);
        return ring_gap(p, s) <= ring_gap(e, s);
    endfunction

    // Commit a finished line into the table, evicting overlapped lines
    task automatic place_line(int s, int e, logic [15:0] id);
        int slot;
        int count;
        if (tbl_empty) begin
            slot = 0;
            oldest_idx = 0;
        end
        else begin
            slot  = (newest_idx + 1) % NLINES;
            count = (newest_idx + NLINES - oldest_idx) % NLINES + 1;
            while (count > 0 &&
                   (pos_in_span(tbl_first[oldest_idx], s, e) ||
                    pos_in_span(s, tbl_first[oldest_idx], tbl_term[oldest_idx]) ||
                    oldest_idx == slot)) begin
                oldest_idx = (oldest_idx + 1) % NLINES;
                count--;
            end
            if (count == 0)
                oldest_idx = slot;
        end
        newest_idx = slot;
        tbl_first[slot] = 10'(s);
        tbl_term[slot]  = 10'(e);
        tbl_id[slot]    = id;
        tbl_empty = 1'b0;
    endtask

    function automatic rsp_t slot_desc(int slot);
        rsp_t r;
        r = '0;
        r.status    = ST_OK;
        r.line_no   = tbl_id[slot];
        r.first_pos = tbl_first[slot];
        r.term_pos  = tbl_term[slot];
        return r;
    endfunction

    // Next response for one accepted request; updates the model state
    task automatic predict_response(input req_t q, output rsp_t r);
        int idx;
        r = '0;
        if (q.kind == KIND_APPEND) begin
            if (!open_flag) begin
                open_flag  = 1'b1;
                open_first = wr_pos;
                open_len   = 0;
            end
            if (open_len < NBUF - 1) begin
                store_mem[wr_pos] = q.data_in;
                wr_pos = (wr_pos + 1) % NBUF;
                open_len++;
            end
            else
                open_len = NBUF;
            r.status    = (open_len == NBUF) ? ST_TRUNC : ST_OK;
            r.line_no   = next_id;
            r.first_pos = 10'(open_first);
            if (q.end_of_line) begin
                r.term_pos = 10'(wr_pos);
                store_mem[wr_pos] = 8'h00;
                place_line(open_first, wr_pos, next_id);
                wr_pos = (wr_pos + 1) % NBUF;
                next_id = next_id + 16'd1;
                open_flag = 1'b0;
                open_len  = 0;
            end
        end
        else if (q.kind > KIND_BYTE)
            r.status = ST_NONE;
        else if (open_flag)
            r.status = ST_BUSY;
        else if (q.kind == KIND_BYTE)
            r.data_out = store_mem[q.byte_pos % NBUF];
        else if (tbl_empty)
            r.status = ST_NONE;
        else if (q.kind == KIND_OLDEST)
            r = slot_desc(oldest_idx);
        else if (q.kind == KIND_NEWEST)
            r = slot_desc(newest_idx);
        else begin
            r.status = ST_NONE;
            idx = oldest_idx;
            for (int n = 0; n < NLINES && idx != newest_idx; n++) begin
                if (tbl_id[idx] == q.query_id) begin
                    r = slot_desc((idx + 1) % NLINES);
                    break;
                end
                idx = (idx + 1) % NLINES;
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // ---- stimulus builders; byte reads only touch written positions ----
    function automatic req_t rand_req();
        req_t q;
        q = '0;
        q.data_in     = 8'($urandom);
        q.query_id    = 16'($urandom);
        q.byte_pos    = 10'($urandom);
        q.end_of_line = 1'($urandom);
        return q;
    endfunction

    bit gen_written [NBUF];
    int gen_pos;
    logic [15:0] gen_id;

    task automatic push_line(int len);
        req_t q;
        for (int i = 0; i < len; i++) begin
            q = rand_req();
            q.kind = KIND_APPEND;
            q.end_of_line = (i == len - 1);
            pending_reqs.push_back(q);
            if (i < NBUF - 1) begin
                gen_written[gen_pos] = 1'b1;
                gen_pos = (gen_pos + 1) % NBUF;
            end
        end
        gen_written[gen_pos] = 1'b1;
        gen_pos = (gen_pos + 1) % NBUF;
        gen_id = gen_id + 16'd1;
    endtask

    task automatic push_read(logic [2:0] k);
        req_t q;
        q = rand_req();
        q.kind = k;
        if (k == KIND_BYTE) begin
            // pick a written position; fall back to the last written one
            for (int t = 0; t < 50 && !gen_written[q.byte_pos % NBUF]; t++)
                q.byte_pos = 10'($urandom);
            if (!gen_written[q.byte_pos % NBUF])
                q.byte_pos = 10'((gen_pos + NBUF - 1) % NBUF);
        end
        if (k == KIND_AFTER && $urandom_range(0, 3) != 0)
            q.query_id = gen_id - 16'($urandom_range(1, 70));
        pending_reqs.push_back(q);
    endtask

    // ---- driver: bursts with random gaps, changes at falling edge ----
    int gap_left;
    int burst_left;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid  <= 1'b0;
            req        <= '0;
            gap_left   = 0;
            burst_left = 0;
        end
        else if (!req_valid || req_taken) begin
            // previous transfer taken (or none pending)
            req_taken = 1'b0;
            if (hold_sender || pending_reqs.size() == 0 || gap_left > 0) begin
                req_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end
                else
                    burst_left--;
            end
        end
    end

    // Receiver stall pattern: long stall-free runs alternating with noisy runs
    int stall_phase;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall   <= 1'b0;
            stall_phase = 0;
        end
        else begin
            stall_phase = (stall_phase + 1) % 400;
            rsp_stall <= (stall_phase >= 200) && ($urandom_range(0, 2) == 0);
        end
    end

    // Prediction happens when a request transfers
    always @(posedge clk) begin
        rsp_t r;
        if (rst_n && req_valid && !req_stall) begin
            predict_response(req, r);
            expected_rsps.push_back(r);
            req_taken = 1'b1;
        end
    end

    // ---- monitor ----
    always @(posedge clk) begin
        rsp_t w;
        if (rst_n) begin
            cycle_count++;
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response", 1, 0);
                else begin
                    w = expected_rsps.pop_front();
                    if (rsp.status != w.status)
                        report_mismatch("status", int'(rsp.status), int'(w.status));
                    if (rsp.line_no != w.line_no)
                        report_mismatch("line_no", int'(rsp.line_no), int'(w.line_no));
                    if (rsp.first_pos != w.first_pos)
                        report_mismatch("first_pos", int'(rsp.first_pos),
                                        int'(w.first_pos));
                    if (rsp.term_pos != w.term_pos)
                        report_mismatch("term_pos", int'(rsp.term_pos), int'(w.term_pos));
                    if (rsp.data_out != w.data_out)
                        report_mismatch("data_out", int'(rsp.data_out), int'(w.data_out));
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        req_t q;
        int choice;
        error_count = 0;
        cycle_count = 0;
        hold_sender = 1'b0;
        req_taken   = 1'b0;
        tbl_empty   = 1'b1;
        oldest_idx  = 0;
        newest_idx  = 0;
        open_flag   = 1'b0;
        wr_pos      = 0;
        open_first  = 0;
        open_len    = 0;
        next_id     = 16'd0;
        gen_pos     = 0;
        gen_id      = 16'd0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;

        // Directed: empty-table reads, unknown kinds, busy reads, extremes
        push_read(KIND_OLDEST);
        push_read(KIND_NEWEST);
        push_read(KIND_AFTER);
        for (int k = 5; k < 8; k++)
        begin
            q = rand_req();
            q.kind = 3'(k);
            pending_reqs.push_back(q);
        end
        q = '0;
        q.kind = KIND_APPEND;
        q.data_in = 8'hFF;
        pending_reqs.push_back(q);
        gen_written[gen_pos] = 1'b1;
        gen_pos++;
        // reads while the line is open
        for (int k = 1; k < 5; k++)
        begin
            q = '1;
            q.kind = 3'(k);
            pending_reqs.push_back(q);
        end
        q = '0;
        q.kind = KIND_APPEND;
        q.end_of_line = 1'b1;
        pending_reqs.push_back(q);
        gen_written[gen_pos] = 1'b1;
        gen_pos++;
        gen_id++;
        push_line(1);
        push_line(2);
        push_read(KIND_OLDEST);
        push_read(KIND_NEWEST);
        q = '0;
        q.kind = KIND_AFTER;          // successor of the first line
        pending_reqs.push_back(q);
        q.query_id = 16'd2;           // newest id: not found
        pending_reqs.push_back(q);
        push_read(KIND_BYTE);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender waits until everything has drained
        while (pending_reqs.size() != 0)
            @(posedge clk);
        hold_sender = 1'b1;
        @(posedge clk);
        while (req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        @(negedge clk);
        hold_sender = 1'b0;

        // Truncated line covering the whole store, evicting everything
        push_line(NBUF + 3);
        push_read(KIND_OLDEST);
        push_read(KIND_NEWEST);
        push_read(KIND_BYTE);

        // Random: mostly short lines (table wraps and evicts), reads between
        while (pending_reqs.size() < 1280) begin
            choice = $urandom_range(0, 99);
            if (choice < 45)
                push_line($urandom_range(1, 12));
            else if (choice < 48)
                push_line($urandom_range(30, 200));
            else if (choice < 93)
                push_read(3'($urandom_range(1, 4)));
            else if (choice < 96) begin
                q = rand_req();
                q.kind = 3'($urandom_range(5, 7));
                pending_reqs.push_back(q);
            end
            else begin
                // reads in the middle of an open line
                q = rand_req();
                q.kind = KIND_APPEND;
                q.end_of_line = 1'b0;
                pending_reqs.push_back(q);
                gen_written[gen_pos] = 1'b1;
                gen_pos = (gen_pos + 1) % NBUF;
                push_read(3'($urandom_range(1, 4)));
                push_line($urandom_range(1, 4));
            end
        end
        // Drain
        while (pending_reqs.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
